>>> rtl/ocp_pkg.sv
`default_nettype none
package ocp_pkg;

    localparam int CORDIC_STEPS = 16;
    localparam int MAX_STEPS    = 24;
    localparam int STEP_W       = $clog2(CORDIC_STEPS);

    // cordic datapath, Q2.30 with headroom
    localparam int XY_W = 34;
    localparam int Z_W  = 33;
    localparam logic signed [XY_W-1:0] CORDIC_GAIN_Q30 = 34'sd652032874;

    // shared multiplier operand and product widths
    localparam int MUL_A_W = 17;
    localparam int MUL_B_W = 28;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;

    // configuration register indexes
    localparam int CFG_ADDR_W = 3;
    localparam logic [CFG_ADDR_W-1:0] REG_ORBIT_DISTANCE = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_TARGET_HEIGHT  = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_ANGLE_SPEED    = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_VERTICAL_MIN   = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_VERTICAL_MAX   = 3'd4;

    typedef struct packed {
        logic                    start;
        logic [15:0]             angle;
    } t_cordic_req;

    typedef struct packed {
        logic                    done;
        logic signed [15:0]      sin_q15;
        logic signed [15:0]      cos_q15;
    } t_cordic_rsp;

    // arctangent of 2^-i as a Q2.30 binary angle
    function automatic logic [31:0] atan_q30(input logic [4:0] idx);
        logic [31:0] r;
        case (idx)
            5'd0:  r = 32'h20000000;
            5'd1:  r = 32'h12E4051E;
            5'd2:  r = 32'h09FB385B;
            5'd3:  r = 32'h051111D4;
            5'd4:  r = 32'h028B0D43;
            5'd5:  r = 32'h0145D7E1;
            5'd6:  r = 32'h00A2F61E;
            5'd7:  r = 32'h00517C55;
            5'd8:  r = 32'h0028BE53;
            5'd9:  r = 32'h00145F2F;
            5'd10: r = 32'h000A2F98;
            5'd11: r = 32'h000517CC;
            5'd12: r = 32'h00028BE6;
            5'd13: r = 32'h000145F3;
            5'd14: r = 32'h0000A2F9;
            5'd15: r = 32'h0000517D;
            5'd16: r = 32'h000028BE;
            5'd17: r = 32'h0000145F;
            5'd18: r = 32'h00000A30;
            5'd19: r = 32'h00000518;
            5'd20: r = 32'h0000028C;
            5'd21: r = 32'h00000146;
            5'd22: r = 32'h000000A3;
            5'd23: r = 32'h00000051;
            default: r = 32'h00000000;
        endcase
        return r;
    endfunction

endpackage
`default_nettype wire

>>> rtl/ocp_mul.sv
`default_nettype none
module ocp_mul (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_en,
    input  wire logic signed [ocp_pkg::MUL_A_W-1:0]    i_a,
    input  wire logic signed [ocp_pkg::MUL_B_W-1:0]    i_b,
    output logic signed [ocp_pkg::PROD_W-1:0]          o_prod
);

    logic signed [ocp_pkg::PROD_W-1:0] r_prod;

    // product holds while not enabled
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod <= ocp_pkg::PROD_W'(i_a) * ocp_pkg::PROD_W'(i_b);
        end
    end

    assign o_prod = r_prod;

endmodule
`default_nettype wire

>>> rtl/ocp_cordic.sv
`default_nettype none
module ocp_cordic (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire ocp_pkg::t_cordic_req i_req,
    output ocp_pkg::t_cordic_rsp      o_rsp
);

    localparam int XY_W = ocp_pkg::XY_W;
    localparam int Z_W  = ocp_pkg::Z_W;

    logic signed [XY_W-1:0] r_x, r_y, n_x, n_y;
    logic signed [Z_W-1:0]  r_z, n_z;
    logic [ocp_pkg::STEP_W-1:0] r_iter;
    logic r_run, r_fin, r_done, r_flip;
    logic signed [15:0] r_sin, r_cos;

    logic signed [Z_W-1:0]  z_init, z_fold, atan_z;
    logic                   fold;
    logic signed [XY_W-1:0] x_sh, y_sh, x_fin, y_fin;

    function automatic logic signed [15:0] to_q15(input logic signed [XY_W-1:0] v);
        logic signed [XY_W-1:0] s;
        logic signed [18:0]     r;
        logic signed [15:0]     q;
        s = v + XY_W'(16384);
        r = 19'(s >>> 15);
        if (r > 19'sd32767) begin
            q = 16'sh7FFF;
        end else if (r < -19'sd32768) begin
            q = 16'sh8000;
        end else begin
            q = 16'(r);
        end
        return q;
    endfunction

    // fold the angle into [-90, 90] degrees, remembering the half turn
    always_comb begin
        z_init = Z_W'($signed({i_req.angle, 16'h0000}));
        fold   = 1'b0;
        z_fold = z_init;
        if (z_init > Z_W'(34'sh40000000)) begin
            z_fold = z_init - Z_W'(34'sh80000000);
            fold   = 1'b1;
        end else if (z_init < -Z_W'(34'sh40000000)) begin
            z_fold = z_init + Z_W'(34'sh80000000);
            fold   = 1'b1;
        end
    end

    always_comb begin
        x_sh   = r_x >>> r_iter;
        y_sh   = r_y >>> r_iter;
        atan_z = Z_W'(ocp_pkg::atan_q30(5'(r_iter)));
        if (!r_z[Z_W-1]) begin
            n_x = r_x - y_sh;
            n_y = r_y + x_sh;
            n_z = r_z - atan_z;
        end else begin
            n_x = r_x + y_sh;
            n_y = r_y - x_sh;
            n_z = r_z + atan_z;
        end
        x_fin = r_flip ? -r_x : r_x;
        y_fin = r_flip ? -r_y : r_y;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_fin  <= 1'b0;
            r_done <= 1'b0;
            r_iter <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start && !r_run && !r_fin) begin
                r_run  <= 1'b1;
                r_iter <= '0;
            end else if (r_run) begin
                r_iter <= r_iter + 1'b1;
                if (r_iter == ocp_pkg::STEP_W'(ocp_pkg::CORDIC_STEPS - 1)) begin
                    r_run <= 1'b0;
                    r_fin <= 1'b1;
                end
            end else if (r_fin) begin
                r_fin  <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start && !r_run && !r_fin) begin
            r_x    <= ocp_pkg::CORDIC_GAIN_Q30;
            r_y    <= '0;
            r_z    <= z_fold;
            r_flip <= fold;
        end else if (r_run) begin
            r_x <= n_x;
            r_y <= n_y;
            r_z <= n_z;
        end
        if (r_fin) begin
            r_cos <= to_q15(x_fin);
            r_sin <= to_q15(y_fin);
        end
    end

    assign o_rsp.done    = r_done;
    assign o_rsp.sin_q15 = r_sin;
    assign o_rsp.cos_q15 = r_cos;

endmodule
`default_nettype wire

>>> rtl/orbit_camera_position_top.sv
`default_nettype none
// Orbit camera: each input transfer carries a target position and the pointer offset from
// screen centre. The offset turns a stored horizontal angle (wrapping) and vertical angle
// (clamped to vertical_min/vertical_max), then the camera is placed on a sphere of radius
// orbit_distance around the target raised by target_height. Items are handled one at a
// time: a single shift-add CORDIC unit runs once for the vertical and once for the
// horizontal angle, and one 17x28 multiplier, one product per cycle while enabled, serves
// the angle steps and the four sphere products. The input is taken again as soon as the
// item is finished, even while the previous result still sits in the output register.
// Configuration writes are taken only while no item is in progress.
module orbit_camera_position_top (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    // configuration write channel
    input  wire logic                             i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  wire logic [ocp_pkg::CFG_ADDR_W-1:0]   i_cfg_addr,
    input  wire logic [31:0]                      i_cfg_data,
    // input stream
    input  wire logic                             i_s_axis_tvalid,
    output logic                                  o_s_axis_tready,
    // target_x, target_y, target_z, pointer_dx, pointer_dy
    input  wire logic [119:0]                     i_s_axis_tdata,
    // output stream
    output logic                                  o_m_axis_tvalid,
    input  wire logic                             i_m_axis_tready,
    // camera_x, camera_y, camera_z, look_x, look_y, look_z
    output logic [191:0]                          o_m_axis_tdata
);

    localparam int MA = ocp_pkg::MUL_A_W;
    localparam int MB = ocp_pkg::MUL_B_W;
    localparam int PW = ocp_pkg::PROD_W;

    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_HSTEP  = 4'd1;
    localparam logic [3:0] ST_VSTEP  = 4'd2;
    localparam logic [3:0] ST_CLAMP  = 4'd3;
    localparam logic [3:0] ST_VSTART = 4'd4;
    localparam logic [3:0] ST_VWAIT  = 4'd5;
    localparam logic [3:0] ST_HSTART = 4'd6;
    localparam logic [3:0] ST_HWAIT  = 4'd7;
    localparam logic [3:0] ST_M_CVD  = 4'd8;
    localparam logic [3:0] ST_M_SV   = 4'd9;
    localparam logic [3:0] ST_M_SH   = 4'd10;
    localparam logic [3:0] ST_M_CH   = 4'd11;
    localparam logic [3:0] ST_FIN    = 4'd12;

    logic [3:0] r_state, n_state;

    // configuration
    logic [25:0]        r_dist;
    logic [31:0]        r_height;
    logic [15:0]        r_speed;
    logic signed [15:0] r_vmin, r_vmax;

    // item and angle state
    logic [31:0]        r_tx, r_ty, r_tz;
    logic signed [11:0] r_pdx, r_pdy;
    logic [15:0]        r_hang;
    logic signed [15:0] r_vang;
    logic signed [15:0] r_sv, r_cv, r_sh, r_ch;
    logic signed [MB-1:0] r_cvd;
    logic [31:0]        r_dx, r_dy;

    logic               r_out_valid;
    logic [191:0]       r_out_data;

    logic               in_xfer, cfg_xfer, out_free;
    logic               mul_en;
    logic signed [MA-1:0] mul_a;
    logic signed [MB-1:0] mul_b;
    logic signed [PW-1:0] prod;
    logic signed [MB-1:0] prod_q15;

    logic signed [20:0] vstep;
    logic signed [21:0] v_sum, v_clamp;

    logic [31:0]        look_y, dz;

    ocp_pkg::t_cordic_req cor_req;
    ocp_pkg::t_cordic_rsp cor_rsp;

    assign o_s_axis_tready = (r_state == ST_IDLE);
    assign o_cfg_ready     = (r_state == ST_IDLE);
    assign in_xfer         = i_s_axis_tvalid && o_s_axis_tready;
    assign cfg_xfer        = i_cfg_valid && o_cfg_ready;
    assign out_free        = !r_out_valid || i_m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dist   <= 26'd655360;
            r_height <= 32'd65536;
            r_speed  <= 16'd256;
            r_vmin   <= -16'sd8192;
            r_vmax   <= 16'sd8192;
        end else if (cfg_xfer) begin
            case (i_cfg_addr)
                ocp_pkg::REG_ORBIT_DISTANCE: r_dist   <= i_cfg_data[25:0];
                ocp_pkg::REG_TARGET_HEIGHT:  r_height <= i_cfg_data;
                ocp_pkg::REG_ANGLE_SPEED:    r_speed  <= i_cfg_data[15:0];
                ocp_pkg::REG_VERTICAL_MIN:   r_vmin   <= $signed(i_cfg_data[15:0]);
                ocp_pkg::REG_VERTICAL_MAX:   r_vmax   <= $signed(i_cfg_data[15:0]);
                default: ;
            endcase
        end
    end

    // shared multiplier operand select
    always_comb begin
        mul_en = 1'b0;
        mul_a  = '0;
        mul_b  = '0;
        case (r_state)
            ST_HSTEP: begin
                mul_en = 1'b1;
                mul_a  = MA'(r_pdx);
                mul_b  = MB'(r_speed);
            end
            ST_VSTEP: begin
                mul_en = 1'b1;
                mul_a  = MA'(r_pdy);
                mul_b  = MB'(r_speed);
            end
            ST_M_CVD: begin
                mul_en = 1'b1;
                mul_a  = MA'(r_cv);
                mul_b  = MB'(r_dist);
            end
            ST_M_SV: begin
                mul_en = 1'b1;
                mul_a  = MA'(r_sv);
                mul_b  = MB'(r_dist);
            end
            ST_M_SH: begin
                mul_en = 1'b1;
                mul_a  = MA'(r_sh);
                mul_b  = r_cvd;
            end
            ST_M_CH: begin
                mul_en = 1'b1;
                mul_a  = MA'(r_ch);
                mul_b  = r_cvd;
            end
            default: ;
        endcase
    end

    ocp_mul u_mul (
        .i_clk  (i_clk),
        .i_en   (mul_en),
        .i_a    (mul_a),
        .i_b    (mul_b),
        .o_prod (prod)
    );

    always_comb begin
        cor_req.start = (r_state == ST_VSTART) || (r_state == ST_HSTART);
        cor_req.angle = (r_state == ST_VSTART) ? r_vang : r_hang;
    end

    ocp_cordic u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (cor_req),
        .o_rsp   (cor_rsp)
    );

    // floor shifts of the product
    assign prod_q15 = prod[PW-3:15];
    assign vstep    = prod[28:8];

    // upper limit first, lower limit wins when the limits cross
    always_comb begin
        v_sum   = 22'(r_vang) + 22'(vstep);
        v_clamp = v_sum;
        if (v_clamp >= 22'(r_vmax)) begin
            v_clamp = 22'(r_vmax);
        end
        if (v_clamp <= 22'(r_vmin)) begin
            v_clamp = 22'(r_vmin);
        end
    end

    assign look_y = r_ty + r_height;
    assign dz     = -(32'(prod_q15));

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE:   if (in_xfer) n_state = ST_HSTEP;
            ST_HSTEP:  n_state = ST_VSTEP;
            ST_VSTEP:  n_state = ST_CLAMP;
            ST_CLAMP:  n_state = ST_VSTART;
            ST_VSTART: n_state = ST_VWAIT;
            ST_VWAIT:  if (cor_rsp.done) n_state = ST_HSTART;
            ST_HSTART: n_state = ST_HWAIT;
            ST_HWAIT:  if (cor_rsp.done) n_state = ST_M_CVD;
            ST_M_CVD:  n_state = ST_M_SV;
            ST_M_SV:   n_state = ST_M_SH;
            ST_M_SH:   n_state = ST_M_CH;
            ST_M_CH:   n_state = ST_FIN;
            ST_FIN:    if (out_free) n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_hang      <= '0;
            r_vang      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_VSTEP) begin
                r_hang <= r_hang - prod[23:8];
            end
            if (r_state == ST_CLAMP) begin
                r_vang <= 16'(v_clamp);
            end
            if (r_state == ST_FIN && out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_tx  <= i_s_axis_tdata[31:0];
            r_ty  <= i_s_axis_tdata[63:32];
            r_tz  <= i_s_axis_tdata[95:64];
            r_pdx <= $signed(i_s_axis_tdata[107:96]);
            r_pdy <= $signed(i_s_axis_tdata[119:108]);
        end
        if (r_state == ST_VWAIT && cor_rsp.done) begin
            r_sv <= cor_rsp.sin_q15;
            r_cv <= cor_rsp.cos_q15;
        end
        if (r_state == ST_HWAIT && cor_rsp.done) begin
            r_sh <= cor_rsp.sin_q15;
            r_ch <= cor_rsp.cos_q15;
        end
        if (r_state == ST_M_SV) begin
            r_cvd <= prod_q15;
        end
        if (r_state == ST_M_SH) begin
            r_dy <= 32'(prod_q15);
        end
        if (r_state == ST_M_CH) begin
            r_dx <= 32'(prod_q15);
        end
        if (r_state == ST_FIN && out_free) begin
            r_out_data <= {r_tz, look_y, r_tx, r_tz + dz, look_y + r_dy, r_tx + r_dx};
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

`ifndef SYNTHESIS
    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer |=> r_state == ST_HSTEP)
        else $error("input transfer did not start the sequence");

    a_cordic_done_waited: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cor_rsp.done |-> (r_state == ST_VWAIT || r_state == ST_HWAIT))
        else $error("cordic finished outside a wait state");

    a_vang_in_limits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_VSTART && r_vmin <= r_vmax) |-> (r_vang >= r_vmin && r_vang <= r_vmax))
        else $error("vertical angle outside limits after clamp");

    a_result_from_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_axis_tvalid) |-> $past(r_state) == ST_FIN)
        else $error("result raised outside the final step");
`endif

endmodule
`default_nettype wire

>>> tb/sv/tb_orbit_camera_position_top.sv
`timescale 1ns / 1ps

module tb_orbit_camera_position_top;

    typedef struct packed {
        logic signed [11:0] pointer_dy;
        logic signed [11:0] pointer_dx;
        logic signed [31:0] target_z;
        logic signed [31:0] target_y;
        logic signed [31:0] target_x;
    } t_frame_in;

    typedef struct packed {
        logic [31:0] look_z;
        logic [31:0] look_y;
        logic [31:0] look_x;
        logic [31:0] camera_z;
        logic [31:0] camera_y;
        logic [31:0] camera_x;
    } t_pose;

    typedef enum logic [1:0] {JOB_FRAME, JOB_REG, JOB_SYNC} t_job_kind;

    typedef struct {
        t_job_kind                      kind;
        t_frame_in                      frame;
        logic [ocp_pkg::CFG_ADDR_W-1:0] addr;
        logic [31:0]                    data;
        int unsigned                    gap;
    } t_job;

    localparam longint GAIN_Q30     = 64'd652032874;
    localparam longint QUARTER_TURN = 64'h4000_0000;
    localparam longint HALF_TURN    = 64'h8000_0000;
    localparam int     NUM_STEPS    = (ocp_pkg::CORDIC_STEPS > ocp_pkg::MAX_STEPS) ?
                                      ocp_pkg::MAX_STEPS : ocp_pkg::CORDIC_STEPS;

    // arctan(2^-i) as a Q2.30 binary angle
    longint atan_lut [24] = '{
        64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4,
        64'h028B0D43, 64'h0145D7E1, 64'h00A2F61E, 64'h00517C55,
        64'h0028BE53, 64'h00145F2F, 64'h000A2F98, 64'h000517CC,
        64'h00028BE6, 64'h000145F3, 64'h0000A2F9, 64'h0000517D,
        64'h000028BE, 64'h0000145F, 64'h00000A30, 64'h00000518,
        64'h0000028C, 64'h00000146, 64'h000000A3, 64'h00000051
    };

    string field_name [6] = '{"camera_x", "camera_y", "camera_z",
                              "look_x", "look_y", "look_z"};

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    logic                           cfg_valid = 1'b0;
    logic [ocp_pkg::CFG_ADDR_W-1:0] cfg_addr  = '0;
    logic [31:0]                    cfg_data  = '0;
    wire                            cfg_ready;
    logic                           s_valid   = 1'b0;
    t_frame_in                      s_frame   = '0;
    wire                            s_ready;
    wire                            m_valid;
    logic                           m_ready   = 1'b0;
    wire  [191:0]                   m_data;

    // predictor copy of the registers and angles
    logic [25:0]        pr_distance = 26'd655360;
    logic signed [31:0] pr_height   = 32'sd65536;
    logic [15:0]        pr_speed    = 16'd256;
    logic signed [15:0] pr_vmin     = -16'sd8192;
    logic signed [15:0] pr_vmax     = 16'sd8192;
    logic [15:0]        pr_hangle   = '0;
    logic signed [15:0] pr_vangle   = '0;

    t_job        jobs [$];
    t_pose       poses_expected [$];
    int unsigned frames_sent = 0;
    int unsigned poses_seen  = 0;
    int unsigned wait_cnt    = 0;
    int unsigned stall_cnt   = 0;
    int unsigned n_err       = 0;
    bit          src_lazy    = 1'b1;
    bit          sink_calm   = 1'b0;

    orbit_camera_position_top dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (cfg_ready),
        .i_cfg_addr      (cfg_addr),
        .i_cfg_data      (cfg_data),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_frame),
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (m_data)
    );

    always #5 i_clk = ~i_clk;

    function automatic longint round_q15(input longint v);
        longint r;
        r = (v + 64'sd16384) >>> 15;
        if (r > 32767) r = 32767;
        if (r < -32768) r = -32768;
        return r;
    endfunction

    function automatic void cordic_sincos(input logic [15:0] ang, output longint s,
                                          output longint c);
        longint x, y, z, t;
        bit     flip;
        x    = GAIN_Q30;
        y    = 0;
        z    = longint'($signed({ang, 16'h0000}));
        flip = 1'b0;
        // fold into [-90, 90] degrees, undo with a sign flip
        if (z > QUARTER_TURN) begin
            z    = z - HALF_TURN;
            flip = 1'b1;
        end else if (z < -QUARTER_TURN) begin
            z    = z + HALF_TURN;
            flip = 1'b1;
        end
        for (int i = 0; i < NUM_STEPS; i++) begin
            if (z >= 0) begin
                t = x - (y >>> i);
                y = y + (x >>> i);
                z = z - atan_lut[i];
            end else begin
                t = x + (y >>> i);
                y = y - (x >>> i);
                z = z + atan_lut[i];
            end
            x = t;
        end
        if (flip) begin
            x = -x;
            y = -y;
        end
        c = round_q15(x);
        s = round_q15(y);
    endfunction

    function automatic t_pose place_camera(input t_frame_in f);
        longint      hstep, vstep, v, sh, ch, sv, cv, d, cvd;
        logic [31:0] ly;
        t_pose       p;
        hstep = (longint'(f.pointer_dx) * longint'(pr_speed)) >>> 8;
        vstep = (longint'(f.pointer_dy) * longint'(pr_speed)) >>> 8;
        pr_hangle = 16'(longint'(pr_hangle) - hstep);
        v = longint'(pr_vangle) + vstep;
        // max first, so crossed limits end on the minimum
        if (v >= pr_vmax) v = pr_vmax;
        if (v <= pr_vmin) v = pr_vmin;
        pr_vangle = 16'(v);
        cordic_sincos(16'(v), sv, cv);
        cordic_sincos(pr_hangle, sh, ch);
        d   = longint'(pr_distance);
        cvd = (cv * d) >>> 15;
        ly  = f.target_y + pr_height;
        p.look_x   = f.target_x;
        p.look_y   = ly;
        p.look_z   = f.target_z;
        p.camera_x = f.target_x + 32'((sh * cvd) >>> 15);
        p.camera_y = ly + 32'((sv * d) >>> 15);
        p.camera_z = f.target_z - 32'((ch * cvd) >>> 15);
        return p;
    endfunction

    function automatic void write_shadow_reg(input logic [ocp_pkg::CFG_ADDR_W-1:0] a,
                                             input logic [31:0] v);
        case (a)
            ocp_pkg::REG_ORBIT_DISTANCE: pr_distance = v[25:0];
            ocp_pkg::REG_TARGET_HEIGHT:  pr_height   = v;
            ocp_pkg::REG_ANGLE_SPEED:    pr_speed    = v[15:0];
            ocp_pkg::REG_VERTICAL_MIN:   pr_vmin     = v[15:0];
            ocp_pkg::REG_VERTICAL_MAX:   pr_vmax     = v[15:0];
            default: ;
        endcase
    endfunction

    // input and configuration driver
    always @(posedge i_clk) begin : drive
        t_job        head;
        bit          in_busy, cfg_busy, in_fire, nxt_s_valid, nxt_cfg_valid;
        int unsigned nxt_wait;
        if (!i_rst_n) begin
            s_valid   <= 1'b0;
            cfg_valid <= 1'b0;
            wait_cnt  <= 0;
        end else begin
            in_fire       = s_valid && s_ready;
            in_busy       = s_valid && !in_fire;
            cfg_busy      = cfg_valid;
            nxt_s_valid   = in_busy;
            nxt_cfg_valid = cfg_valid;
            nxt_wait      = wait_cnt;
            if (in_fire) begin
                poses_expected.push_back(place_camera(s_frame));
                frames_sent <= frames_sent + 1;
            end
            if (cfg_valid && cfg_ready) begin
                write_shadow_reg(cfg_addr, cfg_data);
                cfg_busy      = 1'b0;
                nxt_cfg_valid = 1'b0;
            end
            if (!in_busy && !cfg_busy && jobs.size() != 0) begin
                head = jobs[0];
                case (head.kind)
                    JOB_FRAME: begin
                        if (wait_cnt >= head.gap) begin
                            jobs.delete(0);
                            s_frame     <= head.frame;
                            nxt_s_valid = 1'b1;
                            nxt_wait    = 0;
                        end else begin
                            nxt_wait = wait_cnt + 1;
                        end
                    end
                    JOB_REG: begin
                        // registers only change with the block idle
                        if (!in_fire && frames_sent == poses_seen) begin
                            jobs.delete(0);
                            cfg_addr      <= head.addr;
                            cfg_data      <= head.data;
                            nxt_cfg_valid = 1'b1;
                        end
                    end
                    default: begin
                        if (!in_fire && frames_sent == poses_seen) jobs.delete(0);
                    end
                endcase
            end
            s_valid   <= nxt_s_valid;
            cfg_valid <= nxt_cfg_valid;
            wait_cnt  <= nxt_wait;
        end
    end

    // result monitor and output stall generator
    always @(posedge i_clk) begin : watch
        logic [191:0] got, want;
        int unsigned  nxt_stall;
        if (!i_rst_n) begin
            m_ready   <= 1'b0;
            stall_cnt <= 0;
        end else begin
            nxt_stall = stall_cnt;
            if (m_valid && m_ready) begin
                poses_seen <= poses_seen + 1;
                got = m_data;
                if (poses_expected.size() == 0) begin
                    n_err++;
                    if (n_err <= 10) $display("unexpected result transfer: %h", got);
                end else begin
                    want = poses_expected.pop_front();
                    for (int k = 0; k < 6; k++) begin
                        if (got[k*32 +: 32] !== want[k*32 +: 32]) begin
                            n_err++;
                            if (n_err <= 10)
                                $display("mismatch %s: expected %h, got %h", field_name[k],
                                         want[k*32 +: 32], got[k*32 +: 32]);
                        end
                    end
                end
                nxt_stall = sink_calm ? 0 : $urandom_range(0, 7);
                if ($urandom_range(0, 63) == 0) sink_calm = !sink_calm;
            end else if (nxt_stall > 0) begin
                nxt_stall = nxt_stall - 1;
            end
            stall_cnt <= nxt_stall;
            m_ready   <= (nxt_stall == 0);
        end
    end

    task automatic push_frame(input logic [31:0] tx, input logic [31:0] ty,
                              input logic [31:0] tz, input logic [11:0] dx,
                              input logic [11:0] dy);
        t_job j;
        j.kind             = JOB_FRAME;
        j.frame.target_x   = tx;
        j.frame.target_y   = ty;
        j.frame.target_z   = tz;
        j.frame.pointer_dx = dx;
        j.frame.pointer_dy = dy;
        j.addr             = '0;
        j.data             = '0;
        j.gap              = src_lazy ? $urandom_range(0, 7) : 0;
        jobs.push_back(j);
    endtask

    task automatic push_reg(input logic [ocp_pkg::CFG_ADDR_W-1:0] a, input logic [31:0] v);
        t_job j;
        j.kind  = JOB_REG;
        j.frame = '0;
        j.addr  = a;
        j.data  = v;
        j.gap   = 0;
        jobs.push_back(j);
    endtask

    task automatic push_sync();
        t_job j;
        j.kind  = JOB_SYNC;
        j.frame = '0;
        j.addr  = '0;
        j.data  = '0;
        j.gap   = 0;
        jobs.push_back(j);
    endtask

    function automatic logic [11:0] pick_offset();
        case ($urandom_range(0, 7))
            0:       return 12'd0;
            1, 2:    return 12'($urandom_range(0, 4095));
            default: return 12'(int'($urandom_range(0, 64)) - 32);
        endcase
    endfunction

    function automatic logic [31:0] pick_limit();
        case ($urandom_range(0, 7))
            0:       return -32'sd16384;
            1:       return 32'sd16384;
            default: return 32'(int'($urandom_range(0, 32768)) - 16384);
        endcase
    endfunction

    initial begin : stimulus
        logic [31:0] lo, hi, tmp;
        int unsigned n_frames;
        src_lazy = 1'b1;

        // reset settings: cos 0 saturates, target extremes, pointer extremes
        push_frame(32'h0, 32'h0, 32'h0, 12'd0, 12'd0);
        push_frame(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 12'd2047, 12'd2047);
        push_frame(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, -12'sd2048, -12'sd2048);
        push_frame(32'hFFFF_FFFF, 32'h0000_0001, 32'h5555_5555, 12'd1, 12'd0);
        // vertical angle runs into its upper limit
        repeat (5) push_frame($urandom, $urandom, $urandom, 12'd0, 12'd2047);
        push_sync();

        // quarter-turn steps across the fold points, full-range vertical limits
        push_reg(ocp_pkg::REG_ANGLE_SPEED, 32'd2048);
        push_reg(ocp_pkg::REG_VERTICAL_MIN, -32'sd16384);
        push_reg(ocp_pkg::REG_VERTICAL_MAX, 32'sd16384);
        push_reg(ocp_pkg::REG_ORBIT_DISTANCE, 32'h03FF_FFFF);
        push_reg(ocp_pkg::REG_TARGET_HEIGHT, 32'h7FFF_FFFF);
        repeat (4) push_frame($urandom, $urandom, $urandom, -12'sd2048, 12'd0);
        push_frame($urandom, 32'h7FFF_FFFF, $urandom, 12'd0, 12'd2047);
        push_frame($urandom, $urandom, $urandom, 12'd0, -12'sd2048);
        push_frame($urandom, $urandom, $urandom, 12'd0, -12'sd2048);
        push_frame($urandom, $urandom, $urandom, -12'sd1, -12'sd1);

        // crossed limits, no motion, zero radius
        push_reg(ocp_pkg::REG_VERTICAL_MIN, 32'sd4000);
        push_reg(ocp_pkg::REG_VERTICAL_MAX, -32'sd4000);
        push_reg(ocp_pkg::REG_ANGLE_SPEED, 32'd0);
        push_reg(ocp_pkg::REG_ORBIT_DISTANCE, 32'd0);
        push_reg(ocp_pkg::REG_TARGET_HEIGHT, 32'h8000_0000);
        push_frame($urandom, 32'h8000_0000, $urandom, 12'd0, 12'd0);
        push_frame($urandom, $urandom, $urandom, -12'sd2048, 12'd2047);

        // fastest turn rate, horizontal angle wraps
        push_reg(ocp_pkg::REG_ANGLE_SPEED, 32'd65535);
        push_reg(ocp_pkg::REG_VERTICAL_MIN, -32'sd16384);
        push_reg(ocp_pkg::REG_VERTICAL_MAX, 32'sd16384);
        push_reg(ocp_pkg::REG_ORBIT_DISTANCE, 32'd655360);
        push_reg(ocp_pkg::REG_TARGET_HEIGHT, 32'd65536);
        push_frame($urandom, $urandom, $urandom, 12'd2047, -12'sd2048);
        push_frame($urandom, $urandom, $urandom, -12'sd2048, 12'd2047);

        // narrowed limits snap the stored angle back, sub-unit steps floor
        push_reg(ocp_pkg::REG_VERTICAL_MIN, -32'sd100);
        push_reg(ocp_pkg::REG_VERTICAL_MAX, 32'sd100);
        push_reg(ocp_pkg::REG_ANGLE_SPEED, 32'd1);
        push_frame($urandom, $urandom, $urandom, 12'd0, 12'd0);
        push_frame($urandom, $urandom, $urandom, -12'sd1, -12'sd1);

        for (int ph = 0; ph < 15; ph++) begin
            src_lazy = ($urandom_range(0, 3) != 0);
            if ($urandom_range(0, 1)) begin
                case ($urandom_range(0, 5))
                    0:       push_reg(ocp_pkg::REG_ORBIT_DISTANCE, 32'd0);
                    1:       push_reg(ocp_pkg::REG_ORBIT_DISTANCE, 32'h03FF_FFFF);
                    2, 3:    push_reg(ocp_pkg::REG_ORBIT_DISTANCE,
                                      $urandom_range(0, 32'h03FF_FFFF));
                    default: push_reg(ocp_pkg::REG_ORBIT_DISTANCE,
                                      $urandom_range(65536, 1310720));
                endcase
            end
            if ($urandom_range(0, 1)) push_reg(ocp_pkg::REG_TARGET_HEIGHT, $urandom);
            if ($urandom_range(0, 1)) begin
                case ($urandom_range(0, 4))
                    0:       push_reg(ocp_pkg::REG_ANGLE_SPEED, 32'd0);
                    1:       push_reg(ocp_pkg::REG_ANGLE_SPEED, 32'd65535);
                    2:       push_reg(ocp_pkg::REG_ANGLE_SPEED, $urandom_range(0, 65535));
                    default: push_reg(ocp_pkg::REG_ANGLE_SPEED, $urandom_range(1, 1024));
                endcase
            end
            if ($urandom_range(0, 1)) begin
                lo = pick_limit();
                hi = pick_limit();
                // mostly ordered, sometimes left crossed
                if ($urandom_range(0, 4) != 0 && $signed(lo) > $signed(hi)) begin
                    tmp = lo;
                    lo  = hi;
                    hi  = tmp;
                end
                push_reg(ocp_pkg::REG_VERTICAL_MIN, lo);
                push_reg(ocp_pkg::REG_VERTICAL_MAX, hi);
            end
            n_frames = $urandom_range(100, 150);
            for (int k = 0; k < n_frames; k++) begin
                if ($urandom_range(0, 199) == 0) push_sync();
                push_frame($urandom, $urandom, $urandom, pick_offset(), pick_offset());
            end
        end

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (jobs.size() != 0 || s_valid || cfg_valid || frames_sent != poses_seen)
            @(posedge i_clk);
        repeat (100) @(posedge i_clk);

        if (n_err == 0 && poses_expected.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    initial begin : watchdog
        #10_000_000;
        $display("== FAIL ==");
        $finish;
    end

endmodule
